// File: hdl/dtt_pkg.sv
// Package for the debug text terminal: screen geometry, character and command
// codes, and the structs that travel between the front end, the queue and the back end.
// No dependencies.
`timescale 1ns / 1ps

package dtt_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int CELL_W  = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int          RECIP_SHIFT = 16;
    localparam logic [15:0] COL_RECIP   = 16'((1 << RECIP_SHIFT) / COLUMNS);
    localparam logic [15:0] ROW_RECIP   = 16'((1 << RECIP_SHIFT) / ROWS);

    localparam logic [1:0] CMD_DATA = 2'd0;
    localparam logic [1:0] CMD_CTRL = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_PCT     = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] ATTR_RESET = 8'h0F;

    localparam logic [7:0] CTL_CLEAR = 8'd2;
    localparam logic [7:0] CTL_ATTR  = 8'd3;
    localparam logic [7:0] CTL_MOVE  = 8'd4;

    localparam logic [CELL_W-1:0] RESET_CELL = {ATTR_RESET, CH_SPACE};

    typedef struct packed {
        logic              do_write;
        logic              do_scroll;
        logic              do_clear;
        logic              do_read;
        logic              read_ok;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] data;
    } t_op;

    typedef struct packed {
        logic [COL_W-1:0] cursor_column;
        logic [ROW_W-1:0] cursor_row;
        logic [7:0]       text_attribute;
        logic             escape_busy;
    } t_status;

    typedef struct packed {
        t_op     op;
        t_status status;
    } t_entry;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
        return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

    // Remainder of a byte by a constant: the reciprocal product gives the quotient
    // or one less, and a single compare and subtract settles the remainder.
    function automatic logic [7:0] mod_byte(input logic [7:0] b, input logic [15:0] m,
                                            input logic [15:0] recip);
        logic [23:0] prod;
        logic [15:0] v;
        prod = 24'(b) * 24'(recip);
        v    = {8'd0, b} - {8'd0, prod[23:16]} * m;
        if (v >= m) begin
            v = v - m;
        end
        return v[7:0];
    endfunction

endpackage

// File: hdl/dtt_in_if.sv
// Input channel of the debug text terminal: valid, ready and one command item.
// Depends on dtt_pkg.
`timescale 1ns / 1ps

interface dtt_in_if import dtt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       command;
    logic [7:0]       value;
    logic [ROW_W-1:0] read_row;
    logic [COL_W-1:0] read_column;

    modport source(output valid, command, value, read_row, read_column, input ready);
    modport sink(input valid, command, value, read_row, read_column, output ready);
endinterface

// File: hdl/dtt_out_if.sv
// Output channel of the debug text terminal: valid, ready and one result item.
// Depends on dtt_pkg.
`timescale 1ns / 1ps

interface dtt_out_if import dtt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [7:0]       cell_char;
    logic [7:0]       cell_attr;
    logic [COL_W-1:0] cursor_column;
    logic [ROW_W-1:0] cursor_row;
    logic [7:0]       text_attribute;
    logic             escape_busy;

    modport source(output valid, cell_char, cell_attr, cursor_column, cursor_row,
                   text_attribute, escape_busy, input ready);
    modport sink(input valid, cell_char, cell_attr, cursor_column, cursor_row,
                 text_attribute, escape_busy, output ready);
endinterface

// File: hdl/debug_text_terminal_core.sv
// Debug text terminal top level. The back end takes one item at a time through its steps
// pop, execute and result; the result waits while the output stalls.
// A scroll copies each cell below the top row one row up; a clear sweeps every cell.
// After reset a clearing pass fills the screen with spaces in attribute 0x0F; input ready
// stays low meanwhile. Depends on dtt_pkg, the interfaces and submodules.
`timescale 1ns / 1ps

module debug_text_terminal_core import dtt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dtt_in_if.sink    i_in,
    dtt_out_if.source o_out
);

    logic   push_valid;
    logic   push_ready;
    t_entry push_data;
    logic   pop_valid;
    logic   pop_ready;
    t_entry pop_data;
    logic   boot_busy;

    dtt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_boot_busy  (boot_busy),
        .i_push_ready (push_ready),
        .o_push_valid (push_valid),
        .o_push_data  (push_data)
    );

    dtt_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    dtt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_data  (pop_data),
        .o_out       (o_out),
        .o_boot_busy (boot_busy)
    );

endmodule

// File: hdl/dtt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module dtt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

// File: hdl/dtt_front.sv
// Front end: accepts command items, tracks cursor, attribute and parser state,
// and turns each item into one screen operation plus its status. Depends on dtt_pkg, dtt_in_if.
`timescale 1ns / 1ps

module dtt_front import dtt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    dtt_in_if.sink i_in,
    input  logic   i_boot_busy,
    input  logic   i_push_ready,
    output logic   o_push_valid,
    output t_entry o_push_data
);

    localparam logic [2:0] EP_IDLE   = 3'd0;
    localparam logic [2:0] EP_OPEN   = 3'd1;
    localparam logic [2:0] EP_TYPE1  = 3'd2;
    localparam logic [2:0] EP_TYPE2  = 3'd3;
    localparam logic [2:0] EP_PARAM1 = 3'd4;
    localparam logic [2:0] EP_PARAM2 = 3'd5;

    localparam logic [1:0] CP_IDLE = 2'd0;
    localparam logic [1:0] CP_ATTR = 2'd1;
    localparam logic [1:0] CP_COL  = 2'd2;
    localparam logic [1:0] CP_ROW  = 2'd3;

    logic [COL_W-1:0] r_cx, n_cx;
    logic [ROW_W-1:0] r_cy, n_cy;
    logic [7:0]       r_attr, n_attr;
    logic [2:0]       r_esc_phase, n_esc_phase;
    logic [15:0]      r_esc_kind, n_esc_kind;
    logic [1:0]       r_ctl_phase, n_ctl_phase;

    logic       accept;
    logic       put;
    logic       new_line;
    logic [7:0] b;
    logic [7:0] col_mod;
    logic [7:0] row_mod;
    t_op        op;

    function automatic logic is_format_letter(input logic [7:0] c);
        return (c == "d") || (c == "u") || (c == "x") || (c == "X") ||
               (c == "b") || (c == "a") || (c == "s");
    endfunction

    assign i_in.ready   = i_push_ready && !i_boot_busy;
    assign o_push_valid = i_in.valid && !i_boot_busy;
    assign accept       = i_in.valid && i_in.ready;

    assign b       = i_in.value;
    assign col_mod = mod_byte(b, 16'(COLUMNS), COL_RECIP);
    assign row_mod = mod_byte(b, 16'(ROWS), ROW_RECIP);

    always_comb begin
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_attr      = r_attr;
        n_esc_phase = r_esc_phase;
        n_esc_kind  = r_esc_kind;
        n_ctl_phase = r_ctl_phase;
        op          = '0;
        put         = 1'b0;
        new_line    = 1'b0;

        case (i_in.command)
            CMD_DATA: begin
                case (r_esc_phase)
                    EP_IDLE: begin
                        if (b == CH_LF) begin
                            n_cx     = '0;
                            new_line = 1'b1;
                        end else if (b == CH_CR) begin
                            n_cx = '0;
                        end else if (b == CH_PCT) begin
                            n_esc_phase = EP_OPEN;
                        end else begin
                            put = 1'b1;
                        end
                    end
                    EP_OPEN: begin
                        if (b == CH_PCT) begin
                            n_esc_phase = EP_IDLE;
                            put         = 1'b1;
                        end else if (is_format_letter(b)) begin
                            n_esc_phase = EP_TYPE1;
                        end
                    end
                    EP_TYPE1: begin
                        n_esc_kind  = {b, 8'h00};
                        n_esc_phase = EP_TYPE2;
                    end
                    EP_TYPE2: begin
                        n_esc_kind  = {r_esc_kind[15:8], b};
                        n_esc_phase = EP_PARAM1;
                    end
                    EP_PARAM1: begin
                        if (((r_esc_kind[15:8] == "p") || (r_esc_kind[15:8] == "v")) &&
                            (r_esc_kind[7:0] == "r")) begin
                            n_esc_phase = EP_IDLE;
                            n_esc_kind  = '0;
                        end else begin
                            n_esc_phase = EP_PARAM2;
                        end
                    end
                    default: begin
                        n_esc_phase = EP_IDLE;
                        n_esc_kind  = '0;
                    end
                endcase
            end
            CMD_CTRL: begin
                case (r_ctl_phase)
                    CP_IDLE: begin
                        if (b == CTL_CLEAR) begin
                            op.do_clear = 1'b1;
                            op.data     = {r_attr, CH_SPACE};
                            n_cx        = '0;
                            n_cy        = '0;
                        end else if (b == CTL_ATTR) begin
                            n_ctl_phase = CP_ATTR;
                        end else if (b == CTL_MOVE) begin
                            n_ctl_phase = CP_COL;
                        end
                    end
                    CP_ATTR: begin
                        n_attr      = b;
                        n_ctl_phase = CP_IDLE;
                    end
                    CP_COL: begin
                        n_cx        = col_mod[COL_W-1:0];
                        n_ctl_phase = CP_ROW;
                    end
                    default: begin
                        n_cy        = row_mod[ROW_W-1:0];
                        n_ctl_phase = CP_IDLE;
                    end
                endcase
            end
            CMD_READ: begin
                op.do_read = 1'b1;
                op.read_ok = (i_in.read_row < ROW_W'(ROWS)) &&
                             (i_in.read_column < COL_W'(COLUMNS));
                op.addr    = cell_addr(i_in.read_row, i_in.read_column);
            end
            default: begin
            end
        endcase

        if (put) begin
            op.do_write = 1'b1;
            op.addr     = cell_addr(r_cy, r_cx);
            op.data     = {r_attr, b};
            if (r_cx == COL_W'(COLUMNS - 1)) begin
                n_cx     = '0;
                new_line = 1'b1;
            end else begin
                n_cx = r_cx + 1'b1;
            end
        end

        if (new_line) begin
            if (r_cy == ROW_W'(ROWS - 1)) begin
                op.do_scroll = 1'b1;
            end else begin
                n_cy = r_cy + 1'b1;
            end
        end
    end

    assign o_push_data.op                    = op;
    assign o_push_data.status.cursor_column  = n_cx;
    assign o_push_data.status.cursor_row     = n_cy;
    assign o_push_data.status.text_attribute = n_attr;
    assign o_push_data.status.escape_busy    = (n_esc_phase != EP_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx        <= '0;
            r_cy        <= '0;
            r_attr      <= ATTR_RESET;
            r_esc_phase <= EP_IDLE;
            r_esc_kind  <= '0;
            r_ctl_phase <= CP_IDLE;
        end else if (accept) begin
            r_cx        <= n_cx;
            r_cy        <= n_cy;
            r_attr      <= n_attr;
            r_esc_phase <= n_esc_phase;
            r_esc_kind  <= n_esc_kind;
            r_ctl_phase <= n_ctl_phase;
        end
    end

endmodule

// File: hdl/dtt_fifo.sv
// Short queue of screen operations between the front end and the back end.
// Depends on dtt_pkg.
`timescale 1ns / 1ps

module dtt_fifo import dtt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push_valid,
    output logic   o_push_ready,
    input  t_entry i_push_data,
    output logic   o_pop_valid,
    input  logic   i_pop_ready,
    output t_entry o_pop_data
);

    t_entry            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: hdl/dtt_back.sv
// Back end: carries out screen operations on the cell RAM (write, scroll, clear,
// read), runs the clearing pass after reset and drives the result register.
// Depends on dtt_pkg, dtt_out_if, dtt_ram.
`timescale 1ns / 1ps

module dtt_back import dtt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_pop_valid,
    output logic       o_pop_ready,
    input  t_entry     i_pop_data,
    dtt_out_if.source  o_out,
    output logic       o_boot_busy
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_CLEAR  = 3'd2;
    localparam logic [2:0] S_SCROLL = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic              r_boot, n_boot;
    logic              r_pend;
    logic [ADDR_W-1:0] r_pend_addr;
    logic              r_out_valid;
    logic [CELL_W-1:0] r_cell;
    t_status           r_status;
    t_entry            r_ent;

    logic              load_out;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_wa;
    logic [CELL_W-1:0] ram_wd;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_ra;
    logic [CELL_W-1:0] ram_q;

    dtt_ram #(
        .WIDTH(CELL_W),
        .DEPTH(CELLS)
    ) u_cells (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_wa),
        .i_wr_data (ram_wd),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_ra),
        .o_rd_data (ram_q)
    );

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_boot      = r_boot;
        o_pop_ready = 1'b0;
        load_out    = 1'b0;
        ram_we      = 1'b0;
        ram_wa      = '0;
        ram_wd      = '0;
        ram_re      = 1'b0;
        ram_ra      = '0;

        case (r_state)
            S_IDLE: begin
                o_pop_ready = 1'b1;
                if (i_pop_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_ent.op.do_write) begin
                    ram_we = 1'b1;
                    ram_wa = r_ent.op.addr;
                    ram_wd = r_ent.op.data;
                end
                n_idx = '0;
                if (r_ent.op.do_clear) begin
                    n_state = S_CLEAR;
                end else if (r_ent.op.do_scroll) begin
                    n_idx   = ADDR_W'(COLUMNS);
                    n_state = S_SCROLL;
                end else begin
                    ram_re  = r_ent.op.do_read && r_ent.op.read_ok;
                    ram_ra  = r_ent.op.addr;
                    n_state = S_DONE;
                end
            end
            S_CLEAR: begin
                ram_we = 1'b1;
                ram_wa = r_idx;
                ram_wd = r_boot ? RESET_CELL : r_ent.op.data;
                n_idx  = r_idx + 1'b1;
                if (r_idx == ADDR_W'(CELLS - 1)) begin
                    n_boot  = 1'b0;
                    n_state = r_boot ? S_IDLE : S_DONE;
                end
            end
            S_SCROLL: begin
                ram_re = 1'b1;
                ram_ra = r_idx;
                n_idx  = r_idx + 1'b1;
                if (r_idx == ADDR_W'(CELLS - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // The cell read in the previous cycle lands one row higher.
        if (r_pend) begin
            ram_we = 1'b1;
            ram_wa = r_pend_addr;
            ram_wd = ram_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_boot      <= 1'b1;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_boot  <= n_boot;
            r_pend  <= (r_state == S_SCROLL);
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop_ready && i_pop_valid) begin
            r_ent <= i_pop_data;
        end
        r_pend_addr <= ADDR_W'(r_idx - ADDR_W'(COLUMNS));
        if (load_out) begin
            r_cell   <= (r_ent.op.do_read && r_ent.op.read_ok) ? ram_q : '0;
            r_status <= r_ent.status;
        end
    end

    assign o_boot_busy          = r_boot;
    assign o_out.valid          = r_out_valid;
    assign o_out.cell_char      = r_cell[7:0];
    assign o_out.cell_attr      = r_cell[15:8];
    assign o_out.cursor_column  = r_status.cursor_column;
    assign o_out.cursor_row     = r_status.cursor_row;
    assign o_out.text_attribute = r_status.text_attribute;
    assign o_out.escape_busy    = r_status.escape_busy;

endmodule

// File: hdl/dtt_checker.sv
// Port-level checks for the debug text terminal, bound to the top level.
// Depends on dtt_pkg and debug_text_terminal_core.
`timescale 1ns / 1ps

module dtt_checker import dtt_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [7:0]       i_cell_char,
    input logic [7:0]       i_cell_attr,
    input logic [COL_W-1:0] i_cursor_column,
    input logic [ROW_W-1:0] i_cursor_row
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_cell_char) &&
        $stable(i_cell_attr) && $stable(i_cursor_column) && $stable(i_cursor_row))
        else $error("Stalled result changed before its transfer.");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_cursor_column < COL_W'(COLUMNS)) && (i_cursor_row < ROW_W'(ROWS)))
        else $error("Reported cursor lies outside the screen.");

    a_boot_not_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("Input ready while the clearing pass runs.");

    a_boot_no_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result shown right after reset.");

endmodule

bind debug_text_terminal_core dtt_checker u_dtt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_cell_char     (o_out.cell_char),
    .i_cell_attr     (o_out.cell_attr),
    .i_cursor_column (o_out.cursor_column),
    .i_cursor_row    (o_out.cursor_row)
);

// File: tb/debug_text_terminal_core_test.sv
// Self-checking testbench for the debug text terminal: drives data, control, read and
// unused-command transfers through the input channel and predicts every result in a scoreboard.
// Depends on dtt_pkg, dtt_in_if, dtt_out_if and debug_text_terminal_core.
`timescale 1ns / 1ps

module debug_text_terminal_core_test import dtt_pkg::*; ();

    localparam int          CLK_PERIOD   = 20;
    localparam int          RESET_CYCLES = 11;
    localparam int          RANDOM_ITEMS = 550;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          CYCLE_LIMIT  = 6000000;
    localparam int          REPORT_LINES = 40;
    localparam logic [1:0]  CMD_NONE     = 2'd3;
    localparam logic [7:0]  CTL_SUSPEND  = 8'd1;
    localparam logic [7:0]  TYPE_P       = "p";
    localparam logic [7:0]  TYPE_V       = "v";
    localparam logic [7:0]  TYPE_R       = "r";

    typedef enum logic [2:0] {
        ESC_IDLE, ESC_OPEN, ESC_TYPE1, ESC_TYPE2, ESC_PARAM1, ESC_PARAM2
    } t_esc_phase;

    typedef enum logic [1:0] {
        CTRL_IDLE, CTRL_ATTR_BYTE, CTRL_COL_BYTE, CTRL_ROW_BYTE
    } t_ctrl_phase;

    typedef struct packed {
        logic [7:0]       cell_char;
        logic [7:0]       cell_attr;
        logic [COL_W-1:0] cursor_column;
        logic [ROW_W-1:0] cursor_row;
        logic [7:0]       text_attribute;
        logic             escape_busy;
    } t_view;

    function automatic bit is_format_letter(input logic [7:0] b);
        return b == "d" || b == "u" || b == "x" || b == "X" ||
               b == "b" || b == "a" || b == "s";
    endfunction

    class t_terminal_scoreboard;
        logic [CELL_W-1:0] screen [CELLS];
        int unsigned       cur_col;
        int unsigned       cur_row;
        logic [7:0]        attr;
        t_esc_phase        esc;
        logic [7:0]        kind_hi;
        logic [7:0]        kind_lo;
        t_ctrl_phase       ctl;
        t_view             expected_views [$];
        int unsigned       mismatches;
        int unsigned       effective;
        int unsigned       writes;
        int unsigned       reads;
        int unsigned       results;
        int unsigned       scrolls;
        int unsigned       clears;
        int unsigned       escapes;

        function new();
            attr = ATTR_RESET;
            esc = ESC_IDLE;
            ctl = CTRL_IDLE;
            kind_hi = 8'h00;
            kind_lo = 8'h00;
            wipe();
        endfunction

        function void wipe();
            for (int i = 0; i < CELLS; i++) begin
                screen[i] = {attr, CH_SPACE};
            end
            cur_col = 0;
            cur_row = 0;
        endfunction

        function void advance_row();
            cur_row++;
            if (cur_row >= ROWS) begin
                for (int i = 0; i < CELLS - COLUMNS; i++) begin
                    screen[i] = screen[i + COLUMNS];
                end
                cur_row = ROWS - 1;
                scrolls++;
            end
        endfunction

        function void print(input logic [7:0] ch);
            screen[cur_row * COLUMNS + cur_col] = {attr, ch};
            cur_col++;
            if (cur_col >= COLUMNS) begin
                cur_col = 0;
                advance_row();
            end
        endfunction

        function void data_byte(input logic [7:0] b);
            case (esc)
                ESC_IDLE: begin
                    if (b == CH_LF) begin
                        cur_col = 0;
                        advance_row();
                    end else if (b == CH_CR) begin
                        cur_col = 0;
                    end else if (b == CH_PCT) begin
                        esc = ESC_OPEN;
                    end else begin
                        print(b);
                    end
                end
                ESC_OPEN: begin
                    if (b == CH_PCT) begin
                        esc = ESC_IDLE;
                        print(b);
                    end else if (is_format_letter(b)) begin
                        esc = ESC_TYPE1;
                        escapes++;
                    end
                end
                ESC_TYPE1: begin
                    kind_hi = b;
                    kind_lo = 8'h00;
                    esc = ESC_TYPE2;
                end
                ESC_TYPE2: begin
                    kind_lo = b;
                    esc = ESC_PARAM1;
                end
                ESC_PARAM1: begin
                    if ((kind_hi == TYPE_P || kind_hi == TYPE_V) && kind_lo == TYPE_R) begin
                        esc = ESC_IDLE;
                        kind_hi = 8'h00;
                        kind_lo = 8'h00;
                    end else begin
                        esc = ESC_PARAM2;
                    end
                end
                default: begin
                    esc = ESC_IDLE;
                    kind_hi = 8'h00;
                    kind_lo = 8'h00;
                end
            endcase
        endfunction

        // Returns 0 when the byte is a control code that the terminal ignores.
        function bit control_byte(input logic [7:0] b);
            case (ctl)
                CTRL_IDLE: begin
                    if (b == CTL_CLEAR) begin
                        wipe();
                        clears++;
                    end else if (b == CTL_ATTR) begin
                        ctl = CTRL_ATTR_BYTE;
                    end else if (b == CTL_MOVE) begin
                        ctl = CTRL_COL_BYTE;
                    end else begin
                        return 1'b0;
                    end
                end
                CTRL_ATTR_BYTE: begin
                    attr = b;
                    ctl = CTRL_IDLE;
                end
                CTRL_COL_BYTE: begin
                    cur_col = int'(b) % COLUMNS;
                    ctl = CTRL_ROW_BYTE;
                end
                default: begin
                    cur_row = int'(b) % ROWS;
                    ctl = CTRL_IDLE;
                end
            endcase
            return 1'b1;
        endfunction

        function void note_command(input logic [1:0] cmd, input logic [7:0] val,
                                   input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc);
            t_view       v;
            logic [15:0] cell_word;
            v = '0;
            case (cmd)
                CMD_DATA: begin
                    data_byte(val);
                    writes++;
                    effective++;
                end
                CMD_CTRL: begin
                    writes++;
                    if (control_byte(val)) begin
                        effective++;
                    end
                end
                CMD_READ: begin
                    reads++;
                    effective++;
                    if (rr < ROWS && rc < COLUMNS) begin
                        cell_word = screen[int'(rr) * COLUMNS + int'(rc)];
                        v.cell_char = cell_word[7:0];
                        v.cell_attr = cell_word[15:8];
                    end
                end
                default: ;
            endcase
            v.cursor_column = cur_col[COL_W-1:0];
            v.cursor_row = cur_row[ROW_W-1:0];
            v.text_attribute = attr;
            v.escape_busy = (esc != ESC_IDLE);
            expected_views.push_back(v);
        endfunction

        task report(input string msg);
            if (mismatches < REPORT_LINES) begin
                $display("MISMATCH at %0t: %s", $realtime, msg);
            end
            mismatches++;
        endtask

        task check_field(input string name, input int unsigned idx,
                         input logic [7:0] got, input logic [7:0] want);
            if (got !== want) begin
                report($sformatf("result %0d %s got 0x%02h expected 0x%02h",
                                 idx, name, got, want));
            end
        endtask

        task check_result(input t_view got);
            t_view want;
            if (expected_views.size() == 0) begin
                report("result arrived with no transfer waiting for it");
            end else begin
                want = expected_views.pop_front();
                check_field("cell_char", results, got.cell_char, want.cell_char);
                check_field("cell_attr", results, got.cell_attr, want.cell_attr);
                check_field("cursor_column", results, 8'(got.cursor_column),
                            8'(want.cursor_column));
                check_field("cursor_row", results, 8'(got.cursor_row), 8'(want.cursor_row));
                check_field("text_attribute", results, got.text_attribute,
                            want.text_attribute);
                check_field("escape_busy", results, 8'(got.escape_busy), 8'(want.escape_busy));
            end
            results++;
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    int unsigned pattern_age = 0;
    logic [15:0] stall_pattern = 16'hFFFF;
    int unsigned random_base;

    t_terminal_scoreboard term = new();

    dtt_in_if  in_ch ();
    dtt_out_if out_ch ();

    debug_text_terminal_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, term.expected_views.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // The receiver stalls on a 16-bit pattern, renewed each time pattern_age reaches zero.
    always @(posedge i_clk) begin
        if (pattern_age == 0) begin
            stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            pattern_age <= 199;
        end else begin
            pattern_age <= pattern_age - 1;
        end
        out_ch.ready <= stall_pattern[pattern_age % 16];
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
                term.note_command(in_ch.command, in_ch.value, in_ch.read_row,
                                  in_ch.read_column);
            end
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                term.check_result('{out_ch.cell_char, out_ch.cell_attr, out_ch.cursor_column,
                                    out_ch.cursor_row, out_ch.text_attribute,
                                    out_ch.escape_busy});
            end
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic [7:0] val,
                             input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.command <= cmd;
        in_ch.value <= val;
        in_ch.read_row <= rr;
        in_ch.read_column <= rc;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
    endtask

    task automatic put_data(input logic [7:0] b);
        send_item(CMD_DATA, b, ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
    endtask

    task automatic put_ctrl(input logic [7:0] b);
        send_item(CMD_CTRL, b, ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
    endtask

    task automatic read_cell(input int unsigned r, input int unsigned c);
        send_item(CMD_READ, 8'($urandom), ROW_W'(r), COL_W'(c));
    endtask

    function automatic logic [7:0] pick_letter();
        case ($urandom_range(0, 6))
            0: return "d";
            1: return "u";
            2: return "x";
            3: return "X";
            4: return "b";
            5: return "a";
            default: return "s";
        endcase
    endfunction

    task automatic format_escape(input bit broken);
        int unsigned n;
        logic [7:0]  b;
        logic [7:0]  t1;
        logic [7:0]  t2;
        put_data(CH_PCT);
        if (broken) begin
            n = $urandom_range(1, 4);
            repeat (n) put_data(8'($urandom));
        end else begin
            n = $urandom_range(0, 2);
            repeat (n) begin
                if ($urandom_range(0, 3) == 0) begin
                    do b = 8'($urandom); while (b == CH_PCT || is_format_letter(b));
                end else begin
                    b = 8'("0" + $urandom_range(0, 9));
                end
                put_data(b);
            end
            put_data(pick_letter());
            case ($urandom_range(0, 3))
                0: t1 = TYPE_P;
                1: t1 = TYPE_V;
                default: t1 = 8'($urandom);
            endcase
            t2 = ($urandom_range(0, 4) < 3) ? TYPE_R : 8'($urandom);
            put_data(t1);
            put_data(t2);
            put_data(8'($urandom));
            if (!((t1 == TYPE_P || t1 == TYPE_V) && t2 == TYPE_R)) begin
                put_data(8'($urandom));
            end
        end
    endtask

    task automatic random_sequence();
        int unsigned pick;
        int unsigned n;
        logic [7:0]  b;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            n = $urandom_range(1, 12);
            repeat (n) begin
                b = 8'($urandom);
                while ($urandom_range(0, 9) != 0 && (b == CH_LF || b == CH_CR || b == CH_PCT)) begin
                    b = 8'($urandom);
                end
                put_data(b);
            end
        end else if (pick < 38) begin
            put_data(($urandom_range(0, 1) == 0) ? CH_LF : CH_CR);
        end else if (pick < 43) begin
            put_data(CH_PCT);
            put_data(CH_PCT);
        end else if (pick < 60) begin
            format_escape($urandom_range(0, 7) == 0);
        end else if (pick < 66) begin
            put_ctrl(CTL_ATTR);
            put_ctrl(8'($urandom));
        end else if (pick < 76) begin
            put_ctrl(CTL_MOVE);
            put_ctrl(($urandom_range(0, 3) == 0) ? 8'($urandom_range(76, 79)) : 8'($urandom));
            put_ctrl(($urandom_range(0, 3) == 0) ? 8'(ROWS - 1) : 8'($urandom));
        end else if (pick < 78) begin
            put_ctrl(CTL_CLEAR);
        end else if (pick < 92) begin
            n = $urandom_range(1, 4);
            repeat (n) begin
                if ($urandom_range(0, 7) == 0) begin
                    read_cell($urandom_range(0, 31), $urandom_range(0, 127));
                end else begin
                    read_cell($urandom_range(0, ROWS - 1), $urandom_range(0, COLUMNS - 1));
                end
            end
        end else if (pick < 97) begin
            do b = 8'($urandom); while (b == CTL_CLEAR || b == CTL_ATTR || b == CTL_MOVE);
            put_ctrl(b);
        end else if (pick < 99) begin
            send_item(CMD_NONE, 8'($urandom), ROW_W'($urandom), COL_W'($urandom));
        end else begin
            send_item(2'($urandom), 8'($urandom), ROW_W'($urandom), COL_W'($urandom));
        end
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.command = CMD_DATA;
        in_ch.value = 8'h00;
        in_ch.read_row = '0;
        in_ch.read_column = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        read_cell(ROWS - 1, COLUMNS - 1);
        put_data("A");
        put_data(CH_CR);
        put_data(CH_LF);
        put_data(CH_PCT);
        put_data(CH_PCT);
        put_data(CH_PCT);
        put_data("7");
        put_data("d");
        put_data(TYPE_P);
        put_data(TYPE_R);
        put_data(8'h00);
        put_data(CH_PCT);
        put_data("s");
        put_data("a");
        put_data("b");
        put_data(8'h11);
        put_data(8'hFF);
        put_ctrl(CTL_ATTR);
        put_ctrl(8'hFF);
        put_ctrl(CTL_MOVE);
        put_ctrl(8'hFF);
        put_ctrl(8'hFF);
        put_ctrl(CTL_SUSPEND);
        read_cell(0, 0);
        read_cell(31, 127);
        put_ctrl(CTL_CLEAR);
        send_item(CMD_NONE, 8'hFF, '1, '1);

        random_base = term.effective;
        while (term.effective < random_base + RANDOM_ITEMS) random_sequence();
        in_ch.valid <= 1'b0;

        while (term.expected_views.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d writes and %0d reads; %0d results checked in %0d cycles",
                 term.writes, term.reads, term.results, cycle_count);
        $display("Screen work: %0d scrolls, %0d clears, %0d format escapes; %0d mismatches",
                 term.scrolls, term.clears, term.escapes, term.mismatches);
        if (term.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/dtt_pkg.sv
hdl/dtt_in_if.sv
hdl/dtt_out_if.sv
hdl/dtt_ram.sv
hdl/dtt_front.sv
hdl/dtt_fifo.sv
hdl/dtt_back.sv
hdl/debug_text_terminal_core.sv
hdl/dtt_checker.sv
tb/debug_text_terminal_core_test.sv
